// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_ANY(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bbw_pkg.sv =====
package bbw_pkg;

	// window geometry and line store size
	localparam int Box      = 4;
	localparam int MaxWidth = 1024;
	localparam int MaxHeight = 4096;
	localparam int Lines    = Box - 1;
	localparam int IdxW     = $clog2(Box);

	localparam int PixW = 16;
	localparam int ColW = 10;
	localparam int RowW = 12;
	localparam int AddrW = $clog2(MaxWidth);
	// suffix sum over up to Box rows
	localparam int SufW = PixW + $clog2(Box);
	localparam int SumW = 20;
	localparam int WSumW = 21;
	localparam logic [WSumW-1:0] WeightOne = WSumW'(1 << 20);

	typedef logic [SufW-1:0] suf_t;
	// one window column: suffix sums indexed by starting row
	typedef suf_t [Box-1:0] suf_col_t;
	// whole window indexed by column
	typedef suf_col_t [Box-1:0] win_t;

	// one column word of the line store
	typedef struct packed {
		logic [Lines-1:0][PixW-1:0] wgt;
		logic [Lines-1:0][PixW-1:0] pix;
	} line_word_t;

	// description of the results one item causes
	typedef struct packed {
		logic [ColW-1:0] x0;
		logic [RowW-1:0] y0;
		logic            wide;
		logic            tall;
		logic            frame_end;
	} burst_t;

	// burst engine status toward the input side
	typedef struct packed {
		logic busy;
		logic free;
	} burst_stat_t;

endpackage

// ===== rtl/core/box_blur_4x4_weighted_core.sv =====
// Weighted 4x4 box blur over a raster stream of Q0.16 pixels with weights.
// Each result is the sum of the in-bounds pixels (and weights, or 1.0 when
// weights are off) of the 4x4 window whose top-left corner is out_col,
// out_row, exact in Q0.20. One item is taken per clock unless a burst or
// an output stall holds the input. An item that completes k windows holds
// the input until its results issue, one per cycle: k is 1 inside a row, 4
// at a row end or on the last row from its fourth column, 16 at the last
// frame pixel. An item's first result passes the input stage, the window
// and output registers. The line stores need no clearing after reset.
`include "assert_macros.svh"

module box_blur_4x4_weighted_core
	import bbw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config: 0 image_width, 1 image_height, 2 use_weights
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_value[15:0], pixel_weight[31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_col[9:0], out_row[21:10], blur_sum[41:22],
	                               // weight_sum[62:42], zero pad[63]
	output logic        m_tlast,   // run_last
	output logic [0:0]  m_tuser    // frame_done
);

	localparam logic [1:0] RegWidth   = 2'd0;
	localparam logic [1:0] RegHeight  = 2'd1;
	localparam logic [1:0] RegWeights = 2'd2;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic        weights_q;
	logic [10:0] w_eff;
	logic [12:0] h_eff;

	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic [ColW-1:0] c_cur;
	logic [RowW-1:0] r_cur;
	logic [RowW:0]   r_inc;
	logic [ColW:0]   c_next;
	logic [RowW:0]   r_next;
	logic            accept;

	logic            s1_valid;
	logic [PixW-1:0] pv_s1, wv_s1;
	logic [ColW-1:0] c_s1;
	logic [RowW-1:0] r_s1;

	line_word_t  rd_word, wr_word;
	logic [Box-1:0][PixW-1:0] pix_col, wgt_col;
	win_t        pix_win, wgt_win;
	burst_t      desc;
	burst_stat_t bstat;
	logic        win_load, has_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 11'd1024;
			height_q  <= 13'd1024;
			weights_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegWidth:   width_q   <= cfg_data[10:0];
				RegHeight:  height_q  <= cfg_data;
				RegWeights: weights_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp frame size to what the window and line stores allow
	always_comb begin
		if (width_q < 11'(Box)) w_eff = 11'(Box);
		else if (width_q > 11'(MaxWidth)) w_eff = 11'(MaxWidth);
		else w_eff = width_q;
		if (height_q < 13'(Box)) h_eff = 13'(Box);
		else if (height_q > 13'(MaxHeight)) h_eff = 13'(MaxHeight);
		else h_eff = height_q;
	end

	// position of the incoming item, wrapped if the size shrank
	always_comb begin
		if ({1'b0, col_q} >= w_eff) begin
			c_cur = '0;
			r_inc = {1'b0, row_q} + 1'b1;
		end else begin
			c_cur = col_q;
			r_inc = {1'b0, row_q};
		end
		r_cur  = ({1'b0, r_inc} >= {1'b0, h_eff}) ? '0 : r_inc[RowW-1:0];
		c_next = {1'b0, c_cur} + 1'b1;
		r_next = {1'b0, r_cur} + 1'b1;
	end

	assign s_tready = !s1_valid || win_load;
	assign accept   = s_tvalid && s_tready;

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_next >= w_eff) begin
				col_q <= '0;
				row_q <= ({1'b0, r_next} >= {1'b0, h_eff}) ? '0 : r_next[RowW-1:0];
			end else begin
				col_q <= c_next[ColW-1:0];
				row_q <= r_cur;
			end
		end
	end

	// input stage, aligned with the line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (win_load) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pv_s1 <= s_tdata[15:0];
			wv_s1 <= s_tdata[31:16];
			c_s1  <= c_cur;
			r_s1  <= r_cur;
		end
	end

	bbw_line_store u_lines (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (AddrW'(c_cur)),
		.rd_data (rd_word),
		.wr_en   (win_load),
		.wr_addr (AddrW'(c_s1)),
		.wr_data (wr_word)
	);

	// column gather and line shift
	always_comb begin
		for (int i = 0; i < Lines; i++) begin
			pix_col[i] = rd_word.pix[i];
			wgt_col[i] = rd_word.wgt[i];
		end
		pix_col[Box-1] = pv_s1;
		wgt_col[Box-1] = wv_s1;
		for (int i = 0; i < Lines - 1; i++) begin
			wr_word.pix[i] = rd_word.pix[i+1];
			wr_word.wgt[i] = rd_word.wgt[i+1];
		end
		wr_word.pix[Lines-1] = pv_s1;
		wr_word.wgt[Lines-1] = wv_s1;
	end

	assign win_load = s1_valid && bstat.free;

	bbw_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (win_load),
		.pix_col (pix_col),
		.wgt_col (wgt_col),
		.pix_win (pix_win),
		.wgt_win (wgt_win)
	);

	// results this item completes
	always_comb begin
		has_res        = (r_s1 >= RowW'(Box - 1)) && (c_s1 >= ColW'(Box - 1));
		desc.x0        = c_s1 - ColW'(Box - 1);
		desc.y0        = r_s1 - RowW'(Box - 1);
		desc.wide      = ({1'b0, c_s1} == w_eff - 1'b1);
		desc.tall      = ({1'b0, r_s1} == h_eff - 1'b1);
		desc.frame_end = desc.wide && desc.tall;
	end

	bbw_burst u_burst (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (win_load && has_res),
		.desc        (desc),
		.pix_win     (pix_win),
		.wgt_win     (wgt_win),
		.use_weights (weights_q),
		.stat        (bstat),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

	`ASSERT_CLK(a_done_is_last, clk, arst_n, m_tvalid && m_tuser[0] |-> m_tlast, "frame_done without run_last")
	`ASSERT_CLK(a_stall_blocks_input, clk, arst_n, s1_valid && bstat.busy && !bstat.free |-> !s_tready, "input taken during burst")
	`ASSERT_CLK(a_done_row, clk, arst_n, m_tvalid && m_tuser[0] |-> ({1'b0, m_tdata[21:10]} == h_eff - 1'b1), "frame_done off last row")
	`ASSERT_ANY(a_reset_idle, clk, !arst_n |-> !m_tvalid && !bstat.busy, "activity in reset")

endmodule

// ===== rtl/core/bbw_line_store.sv =====
module bbw_line_store
	import bbw_pkg::*;
(
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output line_word_t       rd_data,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  line_word_t       wr_data
);

	line_word_t mem [MaxWidth];
	line_word_t rd_q;

	// one column word per address, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/core/bbw_window.sv =====
module bbw_window
	import bbw_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [Box-1:0][PixW-1:0]   pix_col,
	input  logic [Box-1:0][PixW-1:0]   wgt_col,
	output win_t                       pix_win,
	output win_t                       wgt_win
);

	win_t     pix_q, wgt_q;
	suf_col_t pix_suf, wgt_suf;

	// suffix sums of the new column, bottom row up
	always_comb begin
		pix_suf[Box-1] = SufW'(pix_col[Box-1]);
		wgt_suf[Box-1] = SufW'(wgt_col[Box-1]);
		for (int i = Box - 2; i >= 0; i--) begin
			pix_suf[i] = pix_suf[i+1] + SufW'(pix_col[i]);
			wgt_suf[i] = wgt_suf[i+1] + SufW'(wgt_col[i]);
		end
	end

	// shift window left, new column enters on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			wgt_q <= '0;
		end else if (load) begin
			for (int j = 0; j < Box - 1; j++) begin
				pix_q[j] <= pix_q[j+1];
				wgt_q[j] <= wgt_q[j+1];
			end
			pix_q[Box-1] <= pix_suf;
			wgt_q[Box-1] <= wgt_suf;
		end
	end

	assign pix_win = pix_q;
	assign wgt_win = wgt_q;

endmodule

// ===== rtl/core/bbw_burst.sv =====
module bbw_burst
	import bbw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  burst_t      desc,
	input  win_t        pix_win,
	input  win_t        wgt_win,
	input  logic        use_weights,
	output burst_stat_t stat,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	output logic        m_tlast,
	output logic [0:0]  m_tuser
);

	logic            busy_q;
	burst_t          desc_q;
	logic [IdxW-1:0] dy_q, dx_q;
	logic [IdxW-1:0] dx_max, dy_max;
	logic            emit, last;
	logic [SumW-1:0] psum;
	logic [WSumW-1:0] wsum, wsum_raw;
	logic            valid_q, last_q, done_q;
	logic [63:0]     data_q;

	assign dx_max = desc_q.wide ? IdxW'(Box - 1) : '0;
	assign dy_max = desc_q.tall ? IdxW'(Box - 1) : '0;
	assign last   = (dx_q == dx_max) && (dy_q == dy_max);
	assign emit   = busy_q && (!valid_q || m_tready);

	assign stat.busy = busy_q;
	assign stat.free = !busy_q || (emit && last);

	// window sum from column dx rightward, rows dy and below
	always_comb begin
		psum     = '0;
		wsum_raw = '0;
		for (int j = 0; j < Box; j++) begin
			if (IdxW'(j) >= dx_q) begin
				psum     = psum + SumW'(pix_win[j][dy_q]);
				wsum_raw = wsum_raw + WSumW'(wgt_win[j][dy_q]);
			end
		end
		wsum = use_weights ? wsum_raw : WeightOne;
	end

	// position walk through the burst in raster order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dx_q   <= '0;
			dy_q   <= '0;
			desc_q <= '0;
		end else begin
			if (emit) begin
				if (last) begin
					busy_q <= 1'b0;
				end else if (dx_q == dx_max) begin
					dx_q <= '0;
					dy_q <= dy_q + 1'b1;
				end else begin
					dx_q <= dx_q + 1'b1;
				end
			end
			if (start) begin
				busy_q <= 1'b1;
				desc_q <= desc;
				dx_q   <= '0;
				dy_q   <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= {1'b0, wsum, psum,
				desc_q.y0 + RowW'(dy_q), desc_q.x0 + ColW'(dx_q)};
			last_q <= last;
			done_q <= last && desc_q.frame_end;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = done_q;

endmodule

// ===== tb/sv/box_blur_4x4_weighted_core_tb.sv =====
`timescale 1ns / 1ps

module box_blur_4x4_weighted_core_tb
	import bbw_pkg::*;
();

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_WEIGHTS = 2'd2
	} cfg_reg_e;

	typedef struct {
		logic [ColW-1:0]  col;
		logic [RowW-1:0]  row;
		logic [SumW-1:0]  blur;
		logic [WSumW-1:0] wsum;
		logic             last;
		logic             done;
	} blur_res_t;

	typedef struct {
		logic [PixW-1:0]  pix;
		logic [PixW-1:0]  wgt;
		int               n_res;
		logic [SumW-1:0]  blur0;
		logic [WSumW-1:0] wsum0;
	} dir_row_t;

	localparam int CycleLimit = 1000000;
	localparam logic [PixW-1:0] PixMax = 16'hFFFF;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;

	box_blur_4x4_weighted_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	// blur model state
	logic [PixW-1:0] line_pix [Lines][MaxWidth];
	logic [PixW-1:0] line_wgt [Lines][MaxWidth];
	logic [PixW-1:0] win_pix [Box][Box];
	logic [PixW-1:0] win_wgt [Box][Box];
	int unsigned     col_cnt, row_cnt;
	int unsigned     img_w, img_h;
	bit              use_wgt;

	blur_res_t blur_expected [$];
	int        mismatches;
	int        sender_idle_pct, recv_idle_pct;
	int        hold_reqs, holds_done;
	longint    cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run-time guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// advance the blur model by one item, queue its results; returns count
	function automatic int blur_predict(logic [PixW-1:0] pv, logic [PixW-1:0] wv);
		int unsigned w, h, c, r, y0, y1, x0, x1;
		logic [PixW-1:0] cp [Box];
		logic [PixW-1:0] cw [Box];
		int unsigned sp, sw;
		blur_res_t res;
		int n;
		w = clampu(img_w, Box, MaxWidth);
		h = clampu(img_h, Box, MaxHeight);
		n = 0;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= h) row_cnt = 0;
		c = col_cnt;
		r = row_cnt;
		for (int i = 0; i < Lines; i++) begin
			cp[i] = line_pix[i][c];
			cw[i] = line_wgt[i][c];
		end
		cp[Box-1] = pv;
		cw[Box-1] = wv;
		for (int i = 0; i < Lines - 1; i++) begin
			line_pix[i][c] = line_pix[i+1][c];
			line_wgt[i][c] = line_wgt[i+1][c];
		end
		line_pix[Lines-1][c] = pv;
		line_wgt[Lines-1][c] = wv;
		for (int i = 0; i < Box; i++) begin
			for (int j = 0; j < Box - 1; j++) begin
				win_pix[i][j] = win_pix[i][j+1];
				win_wgt[i][j] = win_wgt[i][j+1];
			end
			win_pix[i][Box-1] = cp[i];
			win_wgt[i][Box-1] = cw[i];
		end
		// windows complete: one inside a row, a burst at row end, last row or frame end
		if (r >= Box - 1 && c >= Box - 1) begin
			y0 = r - (Box - 1);
			y1 = (r == h - 1) ? r : y0;
			x0 = c - (Box - 1);
			x1 = (c == w - 1) ? c : x0;
			for (int unsigned y = y0; y <= y1; y++) begin
				for (int unsigned x = x0; x <= x1; x++) begin
					sp = 0;
					sw = 0;
					for (int unsigned i = y - y0; i < Box; i++) begin
						for (int unsigned j = x - x0; j < Box; j++) begin
							sp += win_pix[i][j];
							sw += win_wgt[i][j];
						end
					end
					res.col  = x[ColW-1:0];
					res.row  = y[RowW-1:0];
					res.blur = sp[SumW-1:0];
					res.wsum = use_wgt ? sw[WSumW-1:0] : WeightOne;
					res.last = (y == y1 && x == x1);
					res.done = res.last && r == h - 1 && c == w - 1;
					blur_expected.push_back(res);
					n++;
				end
			end
		end
		col_cnt = c + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt = r + 1;
			if (row_cnt >= h) row_cnt = 0;
		end
		return n;
	endfunction

	// result checker
	always @(posedge clk) begin
		blur_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (blur_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: %h last %b done %b", m_tdata, m_tlast, m_tuser);
			end else begin
				e = blur_expected.pop_front();
				if (m_tdata[9:0] !== e.col || m_tdata[21:10] !== e.row ||
				    m_tdata[41:22] !== e.blur || m_tdata[62:42] !== e.wsum ||
				    m_tlast !== e.last || m_tuser[0] !== e.done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp col %0d row %0d blur %0d wsum %0d last %b done %b;",
						         e.col, e.row, e.blur, e.wsum, e.last, e.done,
						         " got col %0d row %0d blur %0d wsum %0d last %b done %b",
						         m_tdata[9:0], m_tdata[21:10], m_tdata[41:22],
						         m_tdata[62:42], m_tlast, m_tuser[0]);
				end
			end
		end
	end

	// receiver: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		int hold_left;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_reqs != holds_done) begin
			holds_done++;
			hold_left = 300;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one item until taken, then update the model
	task automatic send_pixel(logic [PixW-1:0] pv, logic [PixW-1:0] wv, output int n);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {wv, pv};
		do @(posedge clk); while (!s_tready);
		n = blur_predict(pv, wv);
		@(negedge clk);
	endtask

	// frame setup while idle; called at a falling edge
	task automatic set_frame(logic [12:0] w, logic [12:0] h, bit uw);
		s_tvalid <= 1'b0;
		wait (blur_expected.size() == 0);
		repeat (6) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_index <= REG_WEIGHTS;
		cfg_data <= {12'd0, uw};
		@(negedge clk);
		cfg_we <= 1'b0;
		img_w = w[10:0];
		img_h = h;
		use_wgt = uw;
		@(negedge clk);
	endtask

	function automatic logic [PixW-1:0] rand_val();
		case ($urandom_range(7))
			0: return '0;
			1: return PixMax;
			default: return PixW'($urandom);
		endcase
	endfunction

	// one whole frame of random content
	task automatic random_frame(logic [12:0] w, logic [12:0] h, bit uw);
		int n;
		int unsigned total;
		set_frame(w, h, uw);
		total = clampu(w[10:0], Box, MaxWidth) * clampu(h, Box, MaxHeight);
		for (int unsigned k = 0; k < total; k++)
			send_pixel(rand_val(), rand_val(), n);
	endtask

	initial begin
		dir_row_t dir_rows [16];
		int n, sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		hold_reqs = 0;
		holds_done = 0;
		cycles = 0;
		sender_idle_pct = 11;
		recv_idle_pct = 77;
		img_w = 1024;
		img_h = 1024;
		use_wgt = 1'b0;
		col_cnt = 0;
		row_cnt = 0;
		for (int i = 0; i < Lines; i++)
			for (int j = 0; j < MaxWidth; j++) begin
				line_pix[i][j] = '0;
				line_wgt[i][j] = '0;
			end
		for (int i = 0; i < Box; i++)
			for (int j = 0; j < Box; j++) begin
				win_pix[i][j] = '0;
				win_wgt[i][j] = '0;
			end

		// smallest frame at full scale: only the last pixel gives results,
		// all 16 of them, the first with a full window
		for (int i = 0; i < 16; i++)
			dir_rows[i] = '{PixMax, PixMax, 0, '0, '0};
		dir_rows[15] = '{PixMax, PixMax, 16, 20'd1048560, 21'd1048560};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_frame(13'd4, 13'd4, 1'b1);
		foreach (dir_rows[i]) begin
			send_pixel(dir_rows[i].pix, dir_rows[i].wgt, n);
			if (n != dir_rows[i].n_res || (n > 0 &&
			    (blur_expected[0].blur !== dir_rows[i].blur0 ||
			     blur_expected[0].wsum !== dir_rows[i].wsum0))) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: %0d results, expected %0d", i, n,
					         dir_rows[i].n_res);
			end
		end

		// three idling phases of small random frames
		for (int ph = 0; ph < 3; ph++) begin
			sender_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 77 : 0;
			recv_idle_pct   = (ph == 0) ? 77 : (ph == 1) ? 11 : 0;
			sent = 0;
			while (sent < 70) begin
				logic [12:0] w, h;
				w = 13'($urandom_range(12));
				h = 13'($urandom_range(8));
				if (ph == 0 && sent == 0)
					hold_reqs++;
				random_frame(w, h, 1'($urandom));
				sent += clampu(w, Box, MaxWidth) * clampu(h, Box, MaxHeight);
			end
		end

		// size extremes: zero and below-minimum sizes clamp to the 4x4 minimum
		random_frame(13'd0, 13'd0, 1'b1);
		random_frame(13'd3, 13'd2, 1'b0);

		s_tvalid <= 1'b0;
		wait (blur_expected.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
